### sv/fpfir_pkg.sv
// shared constants, types and operation codes of the fixed-point fir filter
package fpfir_pkg;

    localparam int NUM_TAPS     = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;

    localparam int COEF_IDX_W = 5;
    localparam int FRAC_W     = 5;
    localparam int OUT_W      = 32;

    // full product and the sum over all taps, which cannot overflow
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS);
    // at least one bit above the output so saturation can always be detected
    localparam int EXT_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W + 1;

    localparam int S_TDATA_W = ((COEF_IDX_W + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(15);

    // tuser codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // per-cell control from the top level
    typedef struct packed {
        logic shift;
        logic coef_we;
        logic hold;
    } t_cell_ctl;

    // partial sum handed from one cell to the next
    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] sum;
    } t_psum;

endpackage

### sv/fixed_point_fir_filter_top.sv
// top level of the fixed-point fir filter: cell chain, control and output stage
//
// direct-form fir filter built as a row of NUM_TAPS tap cells. a transfer with
// tuser = load writes one coefficient into the cell named by coef_index (indexes
// beyond the taps are dropped); the next transfer may follow at once. a transfer
// with tuser = sample shifts the sample row by one cell and every cell forms its
// coefficient-times-sample product in the same cycle; the partial sum then walks
// the chain, one cell per cycle, so the sum is complete once it leaves the last
// cell. the sum is shifted right arithmetically by frac_bits, saturated to 32-bit
// signed and placed in the output register. a sample item therefore occupies the
// block until its sum has left the last cell, which the length of the partial-sum
// walk through the cells sets; s_axis_tready is low after the transfer until then.
// a finished result may wait in the output register while the next item is taken;
// if it still waits when the next sum reaches the last cell, that sum is held there
// and s_axis_tready stays low until the output register frees. frac_bits resets to
// 15; the user must write it through i_cfg_we only while no item is in flight, as
// the block itself does not enforce this. the delay line and coefficients reset to
// zero.
module fixed_point_fir_filter_top import fpfir_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: frac_bits
    input  logic                 i_cfg_we,
    input  logic [FRAC_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata from bit 0: coef_index[4:0], coef_value[15:0], sample[15:0], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: op (load or sample)
    input  logic                 s_axis_tuser,
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata from bit 0: filtered[31:0]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [FRAC_W-1:0]       r_frac_bits;
    logic                    r_start;
    logic                    in_xfer;
    logic                    smp_xfer;
    logic                    ld_xfer;
    logic                    busy;
    logic                    take;
    logic [COEF_IDX_W-1:0]   in_idx;
    logic [COEF_WIDTH-1:0]   in_coef;
    logic [SAMPLE_WIDTH-1:0] in_sample;

    logic [SAMPLE_WIDTH-1:0] smp_chain [NUM_TAPS+1];
    t_psum                   psum      [NUM_TAPS+1];
    t_cell_ctl               ctl       [NUM_TAPS];

    // unpack the input transfer
    assign in_idx    = s_axis_tdata[COEF_IDX_W-1:0];
    assign in_coef   = s_axis_tdata[COEF_IDX_W +: COEF_WIDTH];
    assign in_sample = s_axis_tdata[COEF_IDX_W + COEF_WIDTH +: SAMPLE_WIDTH];

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign smp_xfer = in_xfer && (s_axis_tuser == OP_SAMPLE);
    assign ld_xfer  = in_xfer && (s_axis_tuser == OP_LOAD);

    // busy from the sample transfer until the sum has left the last cell
    always_comb begin
        busy = r_start;
        for (int k = 1; k <= NUM_TAPS; k++) begin
            busy = busy | psum[k].valid;
        end
    end

    assign s_axis_tready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= FRAC_RESET;
            r_start     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frac_bits <= i_cfg_wdata;
            end
            r_start <= smp_xfer;
        end
    end

    // head of the chain: new sample and an empty partial sum
    assign smp_chain[0] = in_sample;
    assign psum[0].valid = r_start;
    assign psum[0].sum   = '0;

    for (genvar i = 0; i < NUM_TAPS; i++) begin : g_cell
        assign ctl[i].shift   = smp_xfer;
        assign ctl[i].coef_we = ld_xfer && (int'(in_idx) == i);
        // only the last cell waits for the output register
        assign ctl[i].hold    = (i == NUM_TAPS - 1) ? !take : 1'b0;

        fpfir_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[i]),
            .i_coef  (in_coef),
            .i_din   (smp_chain[i]),
            .o_dout  (smp_chain[i+1]),
            .i_psum  (psum[i]),
            .o_psum  (psum[i+1])
        );
    end

    fpfir_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frac_bits (r_frac_bits),
        .i_psum      (psum[NUM_TAPS]),
        .o_take      (take),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

### sv/fpfir_cell.sv
// one tap cell: coefficient, delayed sample, product and partial-sum stage
module fpfir_cell import fpfir_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic [COEF_WIDTH-1:0]   i_coef,
    input  logic [SAMPLE_WIDTH-1:0] i_din,
    output logic [SAMPLE_WIDTH-1:0] o_dout,
    input  t_psum                   i_psum,
    output t_psum                   o_psum
);

    logic [COEF_WIDTH-1:0]   r_coef,   n_coef;
    logic [SAMPLE_WIDTH-1:0] r_sample, n_sample;
    logic                    r_valid,  n_valid;
    logic [PROD_W-1:0]       r_prod,   n_prod;
    logic [ACC_W-1:0]        r_sum,    n_sum;

    always_comb begin
        n_coef   = i_ctl.coef_we ? i_coef : r_coef;
        n_sample = i_ctl.shift ? i_din : r_sample;
        n_prod   = r_prod;
        if (i_ctl.shift) begin
            n_prod = PROD_W'($signed(PROD_W'($signed(i_din))) *
                             $signed(PROD_W'($signed(r_coef))));
        end
        n_valid = i_psum.valid | (r_valid & i_ctl.hold);
        n_sum   = r_sum;
        if (i_psum.valid) begin
            n_sum = i_psum.sum + ACC_W'($signed(r_prod));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= '0;
            r_sample <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_coef   <= n_coef;
            r_sample <= n_sample;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_sum  <= n_sum;
    end

    assign o_dout       = r_sample;
    assign o_psum.valid = r_valid;
    assign o_psum.sum   = r_sum;

endmodule

### sv/fpfir_out_stage.sv
// shift, saturation and output register of the filter result
module fpfir_out_stage import fpfir_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [FRAC_W-1:0]    i_frac_bits,
    input  t_psum                i_psum,
    output logic                 o_take,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic [M_TDATA_W-1:0] o_tdata
);

    logic                 r_valid, n_valid;
    logic [OUT_W-1:0]     r_data,  n_data;
    logic [EXT_W-1:0]     ext_sum;
    logic [EXT_W-1:0]     shifted;
    logic [EXT_W-OUT_W:0] top_bits;
    logic [OUT_W-1:0]     sat;

    always_comb begin
        ext_sum  = EXT_W'($signed(i_psum.sum));
        shifted  = EXT_W'($signed(ext_sum) >>> i_frac_bits);
        top_bits = shifted[EXT_W-1:OUT_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            sat = shifted[OUT_W-1:0];
        end else if (shifted[EXT_W-1]) begin
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    assign o_take = !r_valid || i_tready;

    always_comb begin
        n_valid = r_valid && !i_tready;
        n_data  = r_data;
        if (i_psum.valid && o_take) begin
            n_valid = 1'b1;
            n_data  = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = M_TDATA_W'(r_data);

endmodule

### sv/fpfir_checker.sv
// port-level checker of the fixed-point fir filter and its bind
module fpfir_checker import fpfir_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // a result held back keeps its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed while stalled");

    // a sample transfer occupies the cell chain
    a_smp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SAMPLE)) |=> !s_axis_tready)
        else $error("input taken while a sample is in flight");

    // a coefficient load leaves the block free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD)) |=> s_axis_tready)
        else $error("coefficient load stalled the input");

    // a new result means the chain has emptied
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result appeared while the chain was busy");

endmodule

bind fixed_point_fir_filter_top fpfir_checker u_fpfir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
